FILE: hdl/backend_load_balancer_select_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the backend load balancer select block
// Implication checks on the local clock and reset; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BACKEND_LOAD_BALANCER_SELECT_MACROS_SVH
`define BACKEND_LOAD_BALANCER_SELECT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define LBS_ASSERT_SAME(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lbs assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define LBS_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lbs assertion failed");
`else
`define LBS_ASSERT_SAME(lbl, pre, post)
`define LBS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: hdl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// Load balancer select package
// Shared sizes, codes and transaction types.
// ----------------------------------------------------------------------------
package lbs_pkg;
   localparam int MAX_NODES = 16;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int SUM_W     = 16 + IDX_W;
   localparam int CHOSEN_W  = 4;

   typedef enum logic [1:0] {
      OP_SELECT = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SET    = 2'd3
   } op_type;

   localparam logic [2:0] STRAT_RR     = 3'd0;
   localparam logic [2:0] STRAT_LEAST  = 3'd1;
   localparam logic [2:0] STRAT_RANDOM = 3'd2;
   localparam logic [2:0] STRAT_WEIGHT = 3'd3;
   localparam logic [2:0] STRAT_HASH   = 3'd4;

   localparam logic [1:0] KEY_ID = 2'd0;
   localparam logic [1:0] KEY_IP = 2'd1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic CSR_STRATEGY = 1'b0;
   localparam logic CSR_KEY_SRC  = 1'b1;

   typedef struct packed {
      op_type      op;
      logic [15:0] node_id;
      logic [15:0] weight;
      logic [15:0] active_count;
      logic [31:0] random_value;
      logic [63:0] key;
   } cmd_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] weight;
      logic [15:0] active;
   } node_type;
endpackage

FILE: hdl/lbs_front.sv
// ----------------------------------------------------------------------------
// Load balancer front end
// Accepts request transactions, picks the hash key and queues commands.
// ----------------------------------------------------------------------------
module lbs_front import lbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_node_id,
   input  logic [15:0] req_weight,
   input  logic [15:0] req_active_count,
   input  logic [31:0] req_random_value,
   input  logic [63:0] req_id_key_hash,
   input  logic [63:0] req_ip_key_hash,
   input  logic [63:0] req_opcode_key_hash,
   input  logic [1:0]  key_source,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_take
);
   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push_ok, take_ok;
   cmd_type    new_cmd;

   assign req_full  = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign take_ok   = cmd_take && cmd_valid;

   always_comb begin
      new_cmd.op           = op_type'(req_operation);
      new_cmd.node_id      = req_node_id;
      new_cmd.weight       = req_weight;
      new_cmd.active_count = req_active_count;
      new_cmd.random_value = req_random_value;
      case (key_source)
         KEY_ID:  new_cmd.key = req_id_key_hash;
         KEY_IP:  new_cmd.key = req_ip_key_hash;
         default: new_cmd.key = req_opcode_key_hash;
      endcase
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push_ok) - 2'(take_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end
endmodule

FILE: hdl/lbs_div.sv
// ----------------------------------------------------------------------------
// Load balancer modulo unit
// Restoring remainder of a 64-bit dividend, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module lbs_div import lbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      dividend,
   input  logic [SUM_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] remainder
);
   logic [63:0]      dvd_ff, dvd_in;
   logic [SUM_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [SUM_W:0]   trial;

   assign done      = done_ff;
   assign remainder = rem_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int b = 0; b < 2; b++) begin
            trial = {rem_in, dvd_in[63]};
            dvd_in = {dvd_in[62:0], 1'b0};
            if (trial >= {1'b0, dsr_ff}) begin
               trial = trial - {1'b0, dsr_ff};
            end
            rem_in = trial[SUM_W-1:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end
endmodule

FILE: hdl/lbs_back.sv
// ----------------------------------------------------------------------------
// Load balancer back end
// Node table, command sequencer and the result register.
// ----------------------------------------------------------------------------
`include "backend_load_balancer_select_macros.svh"
module lbs_back import lbs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          strategy,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_take,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_status,
   output logic [15:0]         rsp_chosen_id,
   output logic [CHOSEN_W-1:0] rsp_chosen_index
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DIV, S_WPICK, S_READ, S_DONE
   } state_type;

   node_type            table_ff [MAX_NODES];
   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_W-1:0]    count_ff, count_in, k_ff, k_in;
   logic [IDX_W-1:0]    idx_ff, idx_in, best_ff, best_in;
   logic [15:0]         best_val_ff, best_val_in;
   logic [SUM_W-1:0]    acc_ff, acc_in, acc_sum;
   logic [31:0]         rot_ff, rot_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [15:0]         rsp_id_ff, rsp_id_in;
   logic [CHOSEN_W-1:0] rsp_index_ff, rsp_index_in;
   logic                div_start, div_done;
   logic [63:0]         div_dividend;
   logic [SUM_W-1:0]    div_divisor, div_rem;
   logic                we_all, we_active;
   logic [IDX_W-1:0]    waddr;
   node_type            wdata;
   node_type            cur;
   logic                last;

   lbs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign cur              = table_ff[idx_ff];
   assign last             = ({1'b0, idx_ff} == count_ff - CNT_W'(1));
   assign acc_sum          = acc_ff + SUM_W'(cur.weight);
   assign rsp_empty        = !rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_id    = rsp_id_ff;
   assign rsp_chosen_index = rsp_index_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_val_in   = best_val_ff;
      acc_in        = acc_ff;
      rot_in        = rot_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_pop;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_index_in  = rsp_index_ff;
      cmd_take      = 1'b0;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = SUM_W'(count_ff);
      we_all        = 1'b0;
      we_active     = 1'b0;
      waddr         = idx_ff;
      wdata         = cur;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take  = 1'b1;
               cmd_in    = cmd;
               status_in = ST_OK;
               idx_in    = '0;
               k_in      = '0;
               acc_in    = '0;
               state_in  = S_DONE;
               case (cmd.op) inside
                  OP_ADD: begin
                     if (count_ff >= CNT_W'(MAX_NODES)) begin
                        status_in = ST_FULL;
                     end else begin
                        we_all   = 1'b1;
                        waddr    = count_ff[IDX_W-1:0];
                        wdata    = '{id: cmd.node_id, weight: cmd.weight,
                                     active: cmd.active_count};
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE, OP_SET: begin
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        case (strategy) inside
                           STRAT_RR: begin
                              div_start    = 1'b1;
                              div_dividend = 64'(rot_ff);
                              rot_in       = rot_ff + 32'd1;
                              state_in     = S_DIV;
                           end
                           STRAT_RANDOM: begin
                              div_start    = 1'b1;
                              div_dividend = 64'(cmd.random_value);
                              state_in     = S_DIV;
                           end
                           STRAT_HASH: begin
                              div_start    = 1'b1;
                              div_dividend = cmd.key;
                              state_in     = S_DIV;
                           end
                           STRAT_LEAST, STRAT_WEIGHT: state_in = S_SCAN;
                           default: status_in = ST_EMPTY;
                        endcase
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            case (cmd_ff.op)
               OP_REMOVE: begin
                  if (cur.id != cmd_ff.node_id) begin
                     we_all = 1'b1;
                     waddr  = k_ff[IDX_W-1:0];
                     k_in   = k_ff + CNT_W'(1);
                  end
                  if (last) begin
                     count_in = k_in;
                     state_in = S_DONE;
                  end
               end
               OP_SET: begin
                  if (cur.id == cmd_ff.node_id) begin
                     we_active    = 1'b1;
                     wdata.active = cmd_ff.active_count;
                  end
                  if (last) begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  if (strategy == STRAT_LEAST) begin
                     if (idx_ff == '0 || cur.active < best_val_ff) begin
                        best_in     = idx_ff;
                        best_val_in = cur.active;
                     end
                     if (last) begin
                        idx_in   = best_in;
                        state_in = S_READ;
                     end
                  end else begin
                     acc_in = acc_sum;
                     if (last) begin
                        if (acc_sum == '0) begin
                           idx_in   = idx_ff;
                           state_in = S_READ;
                        end else begin
                           div_start    = 1'b1;
                           div_dividend = 64'(cmd_ff.random_value);
                           div_divisor  = acc_sum;
                           state_in     = S_DIV;
                        end
                     end
                  end
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               if (strategy == STRAT_WEIGHT) begin
                  acc_in   = div_rem;
                  idx_in   = '0;
                  state_in = S_WPICK;
               end else begin
                  idx_in   = div_rem[IDX_W-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_WPICK: begin
            if (acc_ff < SUM_W'(cur.weight) || last) begin
               state_in = S_READ;
            end else begin
               acc_in = acc_ff - SUM_W'(cur.weight);
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_in) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (cmd_ff.op == OP_SELECT && status_ff == ST_OK) begin
                  rsp_id_in    = cur.id;
                  rsp_index_in = CHOSEN_W'(idx_ff);
               end else begin
                  rsp_id_in    = '0;
                  rsp_index_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rot_ff       <= rot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      k_ff          <= k_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_val_ff   <= best_val_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_index_ff  <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (we_all) begin
         table_ff[waddr] <= wdata;
      end else if (we_active) begin
         table_ff[waddr].active <= wdata.active;
      end
   end

   `LBS_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CNT_W'(MAX_NODES))
   `LBS_ASSERT_NEXT(a_rsp_held, rsp_valid_ff && !rsp_pop, rsp_valid_ff)
   `LBS_ASSERT_SAME(a_take_idle, cmd_take, state_ff == S_IDLE)
   `LBS_ASSERT_SAME(a_full_status, state_ff == S_DONE && status_ff == ST_FULL,
                    count_ff == CNT_W'(MAX_NODES))
endmodule

FILE: hdl/backend_load_balancer_select.sv
// ----------------------------------------------------------------------------
// Backend load balancer select, top level
// Keeps a compacted table of backend nodes and picks one per select request.
// ----------------------------------------------------------------------------
// Usage: request transactions are pushed on the req_ port while req_full is
// low; each one is an add, a remove by id, a set of the active count or a
// select. Every request yields exactly one response transaction, offered on
// the rsp_ port while rsp_empty is low and taken with rsp_pop. Strategy and
// hash key source are written through the csr_ port while the block is idle.
// Remove and set active count walk the table at one entry a cycle; least
// connections walks it once as well. Round robin, random and hash select
// run the modulo unit. A weighted select sums the weights, runs the modulo
// unit and walks the weights again. An add, or any request on an empty
// table, goes straight to its response.
// The sequencer handles one request at a time; a two-entry command queue takes
// new requests while it works. Reset empties the table, zeroes the rotation
// counter and selects round robin with the client id key. When the receiver
// stalls the response is held and the sequencer waits behind it.
// ----------------------------------------------------------------------------
module backend_load_balancer_select import lbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_node_id,
   input  logic [15:0] req_weight,
   input  logic [15:0] req_active_count,
   input  logic [31:0] req_random_value,
   input  logic [63:0] req_id_key_hash,
   input  logic [63:0] req_ip_key_hash,
   input  logic [63:0] req_opcode_key_hash,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_chosen_id,
   output logic [3:0]  rsp_chosen_index,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [2:0]  csr_wdata
);
   // Configuration registers. User writes only while no transaction is in flight; the block does not enforce it.
   logic [2:0] strategy_ff, strategy_in;
   logic [1:0] key_src_ff, key_src_in;
   logic       cmd_valid, cmd_take;
   cmd_type    cmd;

   always_comb begin
      strategy_in = strategy_ff;
      key_src_in  = key_src_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_STRATEGY: strategy_in = csr_wdata;
            CSR_KEY_SRC:  key_src_in  = csr_wdata[1:0];
            default:      strategy_in = strategy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= STRAT_RR;
         key_src_ff  <= KEY_ID;
      end else begin
         strategy_ff <= strategy_in;
         key_src_ff  <= key_src_in;
      end
   end

   // The front end resolves the hash key at acceptance, so the back end only
   // ever sees the one key it may need.
   lbs_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_node_id         (req_node_id),
      .req_weight          (req_weight),
      .req_active_count    (req_active_count),
      .req_random_value    (req_random_value),
      .req_id_key_hash     (req_id_key_hash),
      .req_ip_key_hash     (req_ip_key_hash),
      .req_opcode_key_hash (req_opcode_key_hash),
      .key_source          (key_src_ff),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_take            (cmd_take)
   );

   // The back end owns the node table and holds the response register.
   lbs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .strategy         (strategy_ff),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_status       (rsp_status),
      .rsp_chosen_id    (rsp_chosen_id),
      .rsp_chosen_index (rsp_chosen_index)
   );
endmodule
